@@ rtl/core/ubxfb_pkg.sv @@
// ubxfb_pkg: shared types and constants for the frame builder
// command record passed from the front end through the queue to the back end
// no dependencies
package ubxfb_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] MAX_PAYLOAD = 8'd255;

  // input action codes
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_PAYLOAD = 1'b1;

  // kind of work handed to the back end
  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STRAY   = 2'd2
  } cmd_kind_t;

  // one queued command: bytes to send plus the checksum that closes the frame
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  b0;        // class on a start, data byte on a payload
    logic [7:0]  b1;        // id on a start
    logic [7:0]  b2;        // length low byte on a start
    logic [7:0]  chk_a;
    logic [7:0]  chk_b;
    logic        with_chk;  // frame closes with this command
  } cmd_t;

endpackage

@@ rtl/core/ubxfb_channels_if.sv @@
// ubxfb_in_if / ubxfb_out_if: valid/ready channels of the frame builder
// input item channel and frame byte result channel, no dependencies
interface ubxfb_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] msg_class;
  logic [7:0] msg_id;
  logic [7:0] payload_length;
  logic [7:0] payload_byte;

  modport source (output valid, action, msg_class, msg_id, payload_length, payload_byte,
                  input ready);
  modport sink   (input valid, action, msg_class, msg_id, payload_length, payload_byte,
                  output ready);
endinterface

interface ubxfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       run_last;
  logic       frame_end;
  logic       stray_error;

  modport source (output valid, frame_byte, run_last, frame_end, stray_error,
                  input ready);
  modport sink   (input valid, frame_byte, run_last, frame_end, stray_error,
                  output ready);
endinterface

@@ rtl/core/ubx_frame_builder.sv @@
// ubx_frame_builder: top level of the binary command frame encoder
// depends on ubxfb_pkg, ubxfb_channels_if, ubxfb_front, ubxfb_cmd_fifo, ubxfb_back
//
// Turns start and payload items into a framed byte stream: sync bytes 0xB5 0x62,
// class, id, length (low, then a zero high byte), the payload bytes, and the
// two Fletcher checksum bytes. The output sends one byte per cycle while the
// receiver is ready. A start makes six bytes (eight for an empty message), a
// payload byte makes one (three for the last one, which closes the frame), and a
// stray payload byte makes one byte flagged as an error. The front end
// takes an item every cycle while the command queue (QUEUE_DEPTH entries) has
// room; sustained throughput is set by the single output byte lane.
module ubx_frame_builder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  ubxfb_in_if.sink     in_ch,
  ubxfb_out_if.source  out_ch
);
  import ubxfb_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic q_push, q_pop, q_full, q_empty;

  // front end: classify items and keep the running sums
  ubxfb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  // command queue
  ubxfb_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  // back end: byte sequencer and output register
  ubxfb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (head_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTH
  // a stray byte result is a lone zero byte that closes no frame
  a_stray_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.stray_error) |->
      (out_ch.run_last && !out_ch.frame_end && out_ch.frame_byte == 8'd0))
    else $error("stray error result malformed");

  // the closing checksum byte is always the last byte of its item
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_end) |-> out_ch.run_last)
    else $error("frame end without run last");

  // the queue is never written while full or read while empty
  a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full) && !(q_pop && q_empty))
    else $error("command queue overflow or underflow");

  // no result is offered on the first edge out of reset
  a_reset_quiet: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_ch.valid)
    else $error("output valid after reset");
`endif

endmodule

@@ rtl/core/ubxfb_front.sv @@
// ubxfb_front: accepts input items, tracks the open message and the
// running Fletcher sums, and queues one command per item
// depends on ubxfb_pkg and ubxfb_in_if
module ubxfb_front (
  input  logic            clk,
  input  logic            rst_n,
  ubxfb_in_if.sink        in_ch,
  input  logic            q_full,
  output logic            q_push,
  output ubxfb_pkg::cmd_t q_cmd
);
  import ubxfb_pkg::*;

  logic       open_r, open_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic [7:0] sum_a_r, sum_a_nxt;
  logic [7:0] sum_b_r, sum_b_nxt;

  logic [7:0] len_sat;
  logic [7:0] hdr_a2, hdr_a3, hdr_b;
  logic [7:0] pay_a, pay_b, remain_dec;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // header sums over class, id, length low and a zero length high
  always_comb begin
    len_sat = (in_ch.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : in_ch.payload_length;
    hdr_a2  = in_ch.msg_class + in_ch.msg_id;
    hdr_a3  = hdr_a2 + len_sat;
    hdr_b   = in_ch.msg_class + hdr_a2 + hdr_a3 + hdr_a3;
    pay_a      = sum_a_r + in_ch.payload_byte;
    pay_b      = sum_b_r + pay_a;
    remain_dec = remain_r - 8'd1;
  end

  // classify the item and work out the next state
  always_comb begin
    open_nxt   = open_r;
    remain_nxt = remain_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    q_cmd          = '0;
    q_cmd.b0       = in_ch.payload_byte;
    q_cmd.b1       = in_ch.msg_id;
    q_cmd.b2       = len_sat;
    priority if (in_ch.action == ACT_START) begin
      q_cmd.kind     = KIND_START;
      q_cmd.b0       = in_ch.msg_class;
      q_cmd.chk_a    = hdr_a3;
      q_cmd.chk_b    = hdr_b;
      q_cmd.with_chk = (len_sat == 8'd0);
      sum_a_nxt      = hdr_a3;
      sum_b_nxt      = hdr_b;
      open_nxt       = (len_sat != 8'd0);
      remain_nxt     = len_sat;
    end else if (open_r) begin
      q_cmd.kind     = KIND_PAYLOAD;
      q_cmd.chk_a    = pay_a;
      q_cmd.chk_b    = pay_b;
      q_cmd.with_chk = (remain_dec == 8'd0);
      sum_a_nxt      = pay_a;
      sum_b_nxt      = pay_b;
      open_nxt       = (remain_dec != 8'd0);
      remain_nxt     = remain_dec;
    end else begin
      q_cmd.kind     = KIND_STRAY;
    end
  end

  // message state, updated on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      remain_r <= 8'd0;
      sum_a_r  <= 8'd0;
      sum_b_r  <= 8'd0;
    end else if (q_push) begin
      open_r   <= open_nxt;
      remain_r <= remain_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
    end
  end

endmodule

@@ rtl/core/ubxfb_cmd_fifo.sv @@
// ubxfb_cmd_fifo: small command queue between front and back end
// depends on ubxfb_pkg
module ubxfb_cmd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ubxfb_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output ubxfb_pkg::cmd_t head_cmd,
  output logic            empty
);
  import ubxfb_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/ubxfb_back.sv @@
// ubxfb_back: walks each queued command byte by byte into the output register
// depends on ubxfb_pkg and ubxfb_out_if
module ubxfb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  ubxfb_pkg::cmd_t q_head,
  output logic            q_pop,
  ubxfb_out_if.source     out_ch
);
  import ubxfb_pkg::*;

  // byte positions within a start command
  localparam logic [2:0] S_SYNC1  = 3'd0;
  localparam logic [2:0] S_SYNC2  = 3'd1;
  localparam logic [2:0] S_CLASS  = 3'd2;
  localparam logic [2:0] S_ID     = 3'd3;
  localparam logic [2:0] S_LEN_LO = 3'd4;
  localparam logic [2:0] S_LEN_HI = 3'd5;
  localparam logic [2:0] S_CHK_A  = 3'd6;
  localparam logic [2:0] S_CHK_B  = 3'd7;
  // byte positions within a payload command
  localparam logic [2:0] P_DATA   = 3'd0;
  localparam logic [2:0] P_CHK_A  = 3'd1;
  localparam logic [2:0] P_CHK_B  = 3'd2;

  logic [2:0] step_r;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       last_r, end_r, err_r;

  logic [2:0] last_step;
  logic [7:0] cur_byte;
  logic       cur_err;
  logic       is_last, load;

  // select the byte for the current step
  always_comb begin
    last_step = P_DATA;
    cur_byte  = 8'd0;
    cur_err   = 1'b0;
    unique case (q_head.kind)
      KIND_START: begin
        last_step = q_head.with_chk ? S_CHK_B : S_LEN_HI;
        unique case (step_r)
          S_SYNC1:  cur_byte = SYNC_FIRST;
          S_SYNC2:  cur_byte = SYNC_SECOND;
          S_CLASS:  cur_byte = q_head.b0;
          S_ID:     cur_byte = q_head.b1;
          S_LEN_LO: cur_byte = q_head.b2;
          S_LEN_HI: cur_byte = 8'd0;
          S_CHK_A:  cur_byte = q_head.chk_a;
          S_CHK_B:  cur_byte = q_head.chk_b;
          default:  cur_byte = 8'd0;
        endcase
      end
      KIND_PAYLOAD: begin
        last_step = q_head.with_chk ? P_CHK_B : P_DATA;
        unique case (step_r)
          P_DATA:  cur_byte = q_head.b0;
          P_CHK_A: cur_byte = q_head.chk_a;
          P_CHK_B: cur_byte = q_head.chk_b;
          default: cur_byte = 8'd0;
        endcase
      end
      KIND_STRAY: begin
        cur_err = 1'b1;
      end
      default: begin
        cur_err = 1'b1;
      end
    endcase
  end

  assign is_last = (step_r == last_step);
  assign load    = !out_valid_r || out_ch.ready;
  assign q_pop   = load && !q_empty && is_last;

  // step counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= !q_empty;
      if (!q_empty) begin
        step_r <= is_last ? 3'd0 : step_r + 3'd1;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      byte_r <= cur_byte;
      last_r <= is_last;
      end_r  <= is_last && q_head.with_chk;
      err_r  <= cur_err;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.frame_byte  = byte_r;
  assign out_ch.run_last    = last_r;
  assign out_ch.frame_end   = end_r;
  assign out_ch.stray_error = err_r;

endmodule

@@ tb/ubxfb_checker.sv @@
`timescale 1ns / 100ps
// ubxfb_checker: predicts the frame byte stream from input transfers and checks
// every result transfer against it; depends on ubxfb_pkg and ubxfb_channels_if
module ubxfb_checker (
  input  logic clk,
  input  logic rst_n,
  ubxfb_in_if  in_mon,
  ubxfb_out_if out_mon,
  output int   fail_count,
  output int   bytes_due,
  output int   frames_closed,
  output int   strays_seen
);
  import ubxfb_pkg::*;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       run_last;
    logic       frame_end;
    logic       stray_error;
  } frame_out_t;

  // frame bytes predicted but not yet seen on the output
  frame_out_t due_q[$];

  // predictor state
  logic       msg_open;
  logic [7:0] left_bytes;
  logic [7:0] fl_a;
  logic [7:0] fl_b;

  function automatic void push_byte(logic [7:0] b, logic last, logic fend, logic err);
    due_q.push_back(frame_out_t'{b, last, fend, err});
  endfunction

  // running fletcher pair, both sums wrap at 8 bits
  function automatic void fold_byte(logic [7:0] b);
    fl_a = fl_a + b;
    fl_b = fl_b + fl_a;
  endfunction

  function automatic void close_frame();
    push_byte(fl_a, 1'b0, 1'b0, 1'b0);
    push_byte(fl_b, 1'b1, 1'b1, 1'b0);
    msg_open   = 1'b0;
    left_bytes = '0;
  endfunction

  // expected frame bytes for one accepted item
  function automatic void encode_item(logic act, logic [7:0] cls, logic [7:0] id,
                                      logic [7:0] len, logic [7:0] pay);
    if (act == ACT_START) begin
      if (len > MAX_PAYLOAD) len = MAX_PAYLOAD;
      // a start while open drops the old message, sums begin afresh
      fl_a = '0;
      fl_b = '0;
      push_byte(SYNC_FIRST, 1'b0, 1'b0, 1'b0);
      push_byte(SYNC_SECOND, 1'b0, 1'b0, 1'b0);
      push_byte(cls, 1'b0, 1'b0, 1'b0);
      fold_byte(cls);
      push_byte(id, 1'b0, 1'b0, 1'b0);
      fold_byte(id);
      push_byte(len, 1'b0, 1'b0, 1'b0);
      fold_byte(len);
      fold_byte(8'h00);
      if (len == 8'd0) begin
        // empty message closes at once
        push_byte(8'h00, 1'b0, 1'b0, 1'b0);
        close_frame();
      end else begin
        push_byte(8'h00, 1'b1, 1'b0, 1'b0);
        msg_open   = 1'b1;
        left_bytes = len;
      end
    end else if (!msg_open) begin
      // stray payload byte, state untouched
      push_byte(8'h00, 1'b1, 1'b0, 1'b1);
    end else begin
      fold_byte(pay);
      left_bytes = left_bytes - 8'd1;
      if (left_bytes == 8'd0) begin
        push_byte(pay, 1'b0, 1'b0, 1'b0);
        close_frame();
      end else begin
        push_byte(pay, 1'b1, 1'b0, 1'b0);
      end
    end
  endfunction

  function automatic void note_fail(string what, frame_out_t want, frame_out_t got);
    if (fail_count < 10)
      $display("%0t: %s: expected %h/%b/%b/%b, got %h/%b/%b/%b (byte/last/end/err)",
               $time, what, want.frame_byte, want.run_last, want.frame_end, want.stray_error,
               got.frame_byte, got.run_last, got.frame_end, got.stray_error);
    fail_count++;
  endfunction

  // watch both channels on every edge
  always @(posedge clk) begin : watch
    frame_out_t got;
    frame_out_t want;
    if (!rst_n) begin
      due_q.delete();
      msg_open      = 1'b0;
      left_bytes    = '0;
      fl_a          = '0;
      fl_b          = '0;
      fail_count    = 0;
      frames_closed = 0;
      strays_seen   = 0;
    end else begin
      // input transfer
      if (in_mon.valid && in_mon.ready)
        encode_item(in_mon.action, in_mon.msg_class, in_mon.msg_id,
                    in_mon.payload_length, in_mon.payload_byte);
      // result transfer
      if (out_mon.valid && out_mon.ready) begin
        got = frame_out_t'{out_mon.frame_byte, out_mon.run_last, out_mon.frame_end,
                           out_mon.stray_error};
        if (due_q.size() == 0) begin
          note_fail("unexpected frame byte", '0, got);
        end else begin
          want = due_q.pop_front();
          if (got.frame_byte !== want.frame_byte || got.run_last !== want.run_last ||
              got.frame_end !== want.frame_end || got.stray_error !== want.stray_error)
            note_fail("frame byte mismatch", want, got);
        end
        if (got.frame_end === 1'b1) frames_closed++;
        if (got.stray_error === 1'b1) strays_seen++;
      end
    end
    bytes_due = due_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for the frame builder, checking done in ubxfb_checker
// depends on ubxfb_pkg, ubxfb_channels_if, ubx_frame_builder and ubxfb_checker
module tb_top;
  import ubxfb_pkg::*;

  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n;

  ubxfb_in_if  in_ch();
  ubxfb_out_if out_ch();

  int fail_count;
  int bytes_due;
  int frames_closed;
  int strays_seen;
  int items_sent;
  bit steady;    // no idling on either side
  bit hold_req;  // ask the receiver for one long hold-off

  ubx_frame_builder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ubxfb_checker i_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .bytes_due     (bytes_due),
    .frames_closed (frames_closed),
    .strays_seen   (strays_seen)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 26);
        @(posedge clk);
      end
    end
  end

  // one item on the input channel, returns after its transfer
  task automatic offer(input logic act, input logic [7:0] cls, input logic [7:0] id,
                       input logic [7:0] len, input logic [7:0] pay);
    if (!steady && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= act;
    in_ch.msg_class      <= cls;
    in_ch.msg_id         <= id;
    in_ch.payload_length <= len;
    in_ch.payload_byte   <= pay;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // unused fields carry random values
  task automatic send_start(input logic [7:0] cls, input logic [7:0] id,
                            input logic [7:0] len);
    offer(ACT_START, cls, id, len, 8'($urandom));
  endtask

  task automatic send_payload(input logic [7:0] pay);
    offer(ACT_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom), pay);
  endtask

  task automatic send_message(input logic [7:0] len);
    send_start(8'($urandom), 8'($urandom), len);
    repeat (len) send_payload(8'($urandom));
  endtask

  // sender pauses until the last predicted byte has come out
  task automatic drain_out();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (bytes_due == 0);
    @(posedge clk);
  endtask

  // mostly short messages, some empty, a few longer
  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 8'd0;
    if (r < 85) return 8'($urandom_range(6, 1));
    return 8'($urandom_range(40, 7));
  endfunction

  // well-formed messages plus abandoned messages and stray bytes
  task automatic random_traffic(input int count);
    int base;
    int r;
    logic [7:0] len;
    base = items_sent;
    while (items_sent - base < count) begin
      r = $urandom_range(99);
      if (r < 75) begin
        send_message(pick_len());
      end else if (r < 88) begin
        // likely broken message: a start followed by up to six payload bytes
        len = 8'($urandom_range(255, 2));
        send_start(8'($urandom), 8'($urandom), len);
        repeat ($urandom_range(6, 0)) send_payload(8'($urandom));
      end else begin
        send_payload(8'($urandom));
      end
    end
  endtask

  // stimulus
  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.action         <= ACT_START;
    in_ch.msg_class      <= '0;
    in_ch.msg_id         <= '0;
    in_ch.payload_length <= '0;
    in_ch.payload_byte   <= '0;
    steady   = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray bytes straight after reset
    send_payload(8'hFF);
    send_payload(8'h00);
    // empty frames at the field extremes
    send_start(8'h00, 8'h00, 8'd0);
    send_start(8'hFF, 8'hFF, 8'd0);
    // single byte frame, then a short one with extreme bytes
    send_start(8'h06, 8'h01, 8'd1);
    send_payload(8'hAA);
    send_start(8'h80, 8'h7F, 8'd3);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'h55);
    // start while open abandons the first message
    send_start(8'h0A, 8'h0B, 8'd5);
    send_payload(8'h12);
    send_start(8'h01, 8'h02, 8'd2);
    send_payload(8'h34);
    send_payload(8'h56);
    // stray after a closed frame
    send_payload(8'hC3);
    drain_out();

    random_traffic(40);

    // stretch with no idling on either side
    steady = 1'b1;
    random_traffic(30);
    steady = 1'b0;

    // receiver holds off while a full length message is offered
    hold_req = 1'b1;
    send_message(MAX_PAYLOAD);
    drain_out();

    random_traffic(20);

    // wind down
    in_ch.valid <= 1'b0;
    wait (bytes_due == 0);
    repeat (30) @(posedge clk);
    $display("sent %0d items: %0d frames closed, %0d stray bytes flagged, %0d failures",
             items_sent, frames_closed, strays_seen, fail_count);
    $display("included empty and full length frames, abandoned messages and a long stall");
    if (fail_count == 0 && bytes_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d frame bytes outstanding", bytes_due);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
